### rtl/thrac_pkg.sv
`timescale 1ns / 1ps

package thrac_pkg;

  localparam int unsigned SampleTicksDef   = 2000;
  localparam int unsigned BuzzHalfTicksDef = 500;
  localparam int unsigned SetpointStepDef  = 16;

  localparam int unsigned TempW   = 12;
  localparam int unsigned SavedW  = 16;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [KeyW-1:0] KeyUp    = 8'h26;
  localparam logic [KeyW-1:0] KeyDown  = 8'h28;
  localparam logic [KeyW-1:0] KeyEnter = 8'h0D;

  localparam logic [CfgIdxW-1:0] CfgActionMin     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgActionMax     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgActionDefault = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAlarmMin      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAlarmMax      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAlarmDefault  = 3'd5;

  localparam logic signed [TempW-1:0] ActionMinRst     = 12'sd0;
  localparam logic signed [TempW-1:0] ActionMaxRst     = 12'sd1600;
  localparam logic signed [TempW-1:0] ActionDefaultRst = 12'sd480;
  localparam logic signed [TempW-1:0] AlarmMinRst      = 12'sd0;
  localparam logic signed [TempW-1:0] AlarmMaxRst      = 12'sd1600;
  localparam logic signed [TempW-1:0] AlarmDefaultRst  = 12'sd640;

  typedef enum logic [1:0] {
    EvTick    = 2'd0,
    EvKey     = 2'd1,
    EvSample  = 2'd2,
    EvRestore = 2'd3
  } evt_e;

  typedef enum logic [1:0] {
    UiNormal   = 2'd0,
    UiSetAct   = 2'd1,
    UiSetAlarm = 2'd2
  } ui_mode_e;

  localparam logic [1:0] StoreNone   = 2'd0;
  localparam logic [1:0] StoreAction = 2'd1;
  localparam logic [1:0] StoreAlarm  = 2'd2;

  typedef struct packed {
    logic signed [TempW-1:0] action_min;
    logic signed [TempW-1:0] action_max;
    logic signed [TempW-1:0] action_default;
    logic signed [TempW-1:0] alarm_min;
    logic signed [TempW-1:0] alarm_max;
    logic signed [TempW-1:0] alarm_default;
  } cfg_t;

  typedef struct packed {
    evt_e                     kind;
    logic [KeyW-1:0]          key_code;
    logic signed [TempW-1:0]  temperature;
    logic signed [SavedW-1:0] saved_action;
    logic signed [SavedW-1:0] saved_alarm;
  } item_t;

  typedef struct packed {
    logic                    relay_on;
    logic                    alarm_active;
    logic                    buzzer_on;
    logic [1:0]              system_mode;
    logic                    display_update;
    logic signed [TempW-1:0] display_value;
    logic [1:0]              store_request;
    logic signed [TempW-1:0] store_value;
    logic                    sample_due;
  } result_t;

endpackage

### rtl/thermostat_relay_alarm_controller.sv
`timescale 1ns / 1ps
// An item is registered in the input register and its result in the result register.
// Throughput is one item per cycle; the input register drains into the result register
// whenever the result register is empty or its result is transferred in the same cycle.
// Reset is asynchronous and returns all state and configuration registers to their
// default values at once; no item is held back after reset.
module thermostat_relay_alarm_controller import thrac_pkg::*; #(
  parameter int unsigned SAMPLE_TICKS    = SampleTicksDef,
  parameter int unsigned BUZZ_HALF_TICKS = BuzzHalfTicksDef,
  parameter int unsigned SETPOINT_STEP   = SetpointStepDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [TempW-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // key_code, temperature, saved_action, saved_alarm, zero fill
  input  logic [55:0]        s_axis_tdata,
  // event kind
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // relay_on, alarm_active, buzzer_on, system_mode, display_update, display_value,
  // store_request, store_value, sample_due, zero fill
  output logic [39:0]        m_axis_tdata
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    fire;
  result_t res;
  result_t res_q;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.kind         <= evt_e'(s_axis_tuser);
      item_q.key_code     <= s_axis_tdata[7:0];
      item_q.temperature  <= s_axis_tdata[19:8];
      item_q.saved_action <= s_axis_tdata[35:20];
      item_q.saved_alarm  <= s_axis_tdata[51:36];
    end
  end

  thrac_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  thrac_ctrl #(
    .SAMPLE_TICKS    (SAMPLE_TICKS),
    .BUZZ_HALF_TICKS (BUZZ_HALF_TICKS),
    .SETPOINT_STEP   (SETPOINT_STEP)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_q.sample_due, res_q.store_value, res_q.store_request,
                          res_q.display_value, res_q.display_update, res_q.system_mode,
                          res_q.buzzer_on, res_q.alarm_active, res_q.relay_on};

`ifndef SYNTHESIS
  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result register not filled after a transfer into it");

  a_store_with_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.store_request != StoreNone) |-> res_q.display_update)
    else $error("store request without display update");

  a_store_action_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.store_request == StoreAction) |-> res_q.system_mode == UiSetAlarm)
    else $error("action store outside alarm setting mode");

  a_store_alarm_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.store_request == StoreAlarm) |-> res_q.system_mode == UiNormal)
    else $error("alarm store outside normal mode");

  a_due_no_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.sample_due |-> !res_q.display_update && !res_q.store_request[0]
      && !res_q.store_request[1])
    else $error("sample due on a non-tick result");
`endif

endmodule

### rtl/thrac_cfg.sv
`timescale 1ns / 1ps

module thrac_cfg import thrac_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [TempW-1:0]   cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.action_min     <= ActionMinRst;
      cfg_q.action_max     <= ActionMaxRst;
      cfg_q.action_default <= ActionDefaultRst;
      cfg_q.alarm_min      <= AlarmMinRst;
      cfg_q.alarm_max      <= AlarmMaxRst;
      cfg_q.alarm_default  <= AlarmDefaultRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgActionMin:     cfg_q.action_min     <= cfg_wdata_i;
        CfgActionMax:     cfg_q.action_max     <= cfg_wdata_i;
        CfgActionDefault: cfg_q.action_default <= cfg_wdata_i;
        CfgAlarmMin:      cfg_q.alarm_min      <= cfg_wdata_i;
        CfgAlarmMax:      cfg_q.alarm_max      <= cfg_wdata_i;
        CfgAlarmDefault:  cfg_q.alarm_default  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/thrac_ctrl.sv
`timescale 1ns / 1ps

module thrac_ctrl import thrac_pkg::*; #(
  parameter int unsigned SAMPLE_TICKS    = SampleTicksDef,
  parameter int unsigned BUZZ_HALF_TICKS = BuzzHalfTicksDef,
  parameter int unsigned SETPOINT_STEP   = SetpointStepDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int unsigned SW = $clog2(SAMPLE_TICKS + 1);
  localparam int unsigned BW = $clog2(2 * BUZZ_HALF_TICKS + 1);
  localparam int unsigned AW = TempW + 2;

  localparam logic [SW-1:0] SampleCnt = SW'(SAMPLE_TICKS);
  localparam logic [BW-1:0] HalfCnt   = BW'(BUZZ_HALF_TICKS);
  localparam logic [BW-1:0] FullCnt   = BW'(2 * BUZZ_HALF_TICKS);
  localparam logic signed [AW-1:0] Step = AW'(SETPOINT_STEP);

  logic signed [TempW-1:0] temp_q, temp_d;
  logic signed [TempW-1:0] act_q, act_d;
  logic signed [TempW-1:0] alm_q, alm_d;
  ui_mode_e                ui_q, ui_d;
  logic                    relay_q, relay_d;
  logic                    alflag_q, alflag_d;
  logic                    buz_q, buz_d;
  logic [SW-1:0]           st_q, st_d;
  logic [BW-1:0]           bt_q, bt_d;

  logic [SW-1:0]            st_inc;
  logic signed [AW-1:0]     act_up, act_dn, alm_up, alm_dn;
  logic signed [SavedW-1:0] sv_act, sv_alm;
  logic                     do_ctrl;
  result_t                  res;

  assign st_inc = st_q + SW'(1);
  assign act_up = AW'(act_q) + Step;
  assign act_dn = AW'(act_q) - Step;
  assign alm_up = AW'(alm_q) + Step;
  assign alm_dn = AW'(alm_q) - Step;
  assign sv_act = item_i.saved_action;
  assign sv_alm = item_i.saved_alarm;

  always_comb begin
    temp_d   = temp_q;
    act_d    = act_q;
    alm_d    = alm_q;
    ui_d     = ui_q;
    relay_d  = relay_q;
    alflag_d = alflag_q;
    buz_d    = buz_q;
    st_d     = st_q;
    bt_d     = bt_q;
    do_ctrl  = 1'b0;
    res      = '0;

    case (item_i.kind)
      EvTick: begin
        st_d = st_inc;
        if (st_inc >= SampleCnt) begin
          st_d           = '0;
          res.sample_due = 1'b1;
        end
        if (alflag_q) begin
          if (bt_q < HalfCnt) begin
            buz_d = 1'b1;
            bt_d  = bt_q + BW'(1);
          end else if (bt_q < FullCnt) begin
            buz_d = 1'b0;
            bt_d  = bt_q + BW'(1);
          end else begin
            bt_d = '0;
          end
        end else begin
          buz_d = 1'b0;
          bt_d  = '0;
        end
      end
      EvKey: begin
        if (item_i.key_code == KeyUp) begin
          case (ui_q)
            UiSetAct:   act_d = (act_up > AW'(cfg_i.action_max)) ? cfg_i.action_max
                                                                 : act_up[TempW-1:0];
            UiSetAlarm: alm_d = (alm_up > AW'(cfg_i.alarm_max)) ? cfg_i.alarm_max
                                                                : alm_up[TempW-1:0];
            default: ;
          endcase
        end else if (item_i.key_code == KeyDown) begin
          case (ui_q)
            UiSetAct:   act_d = (act_dn < AW'(cfg_i.action_min)) ? cfg_i.action_min
                                                                 : act_dn[TempW-1:0];
            UiSetAlarm: alm_d = (alm_dn < AW'(cfg_i.alarm_min)) ? cfg_i.alarm_min
                                                                : alm_dn[TempW-1:0];
            default: ;
          endcase
        end else if (item_i.key_code == KeyEnter) begin
          case (ui_q)
            UiNormal: ui_d = UiSetAct;
            UiSetAct: begin
              ui_d              = UiSetAlarm;
              res.store_request = StoreAction;
              res.store_value   = act_q;
            end
            UiSetAlarm: begin
              ui_d              = UiNormal;
              res.store_request = StoreAlarm;
              res.store_value   = alm_q;
              do_ctrl           = 1'b1;
            end
            default: ;
          endcase
        end
        res.display_update = 1'b1;
        case (ui_d)
          UiSetAct:   res.display_value = act_d;
          UiSetAlarm: res.display_value = alm_d;
          default:    res.display_value = temp_q;
        endcase
      end
      EvSample: begin
        temp_d = item_i.temperature;
        if (ui_q == UiNormal) begin
          res.display_update = 1'b1;
          res.display_value  = item_i.temperature;
          do_ctrl            = 1'b1;
        end
      end
      EvRestore: begin
        if (sv_act < SavedW'(cfg_i.action_min) || sv_act > SavedW'(cfg_i.action_max)) begin
          act_d = cfg_i.action_default;
        end else begin
          act_d = sv_act[TempW-1:0];
        end
        if (sv_alm < SavedW'(cfg_i.alarm_min) || sv_alm > SavedW'(cfg_i.alarm_max)) begin
          alm_d = cfg_i.alarm_default;
        end else begin
          alm_d = sv_alm[TempW-1:0];
        end
      end
      default: ;
    endcase

    if (do_ctrl) begin
      if (temp_d > act_d) begin
        relay_d = 1'b1;
      end else if (temp_d < act_d) begin
        relay_d = 1'b0;
      end
      alflag_d = (temp_d >= alm_d);
    end

    res.relay_on     = relay_d;
    res.alarm_active = alflag_d;
    res.buzzer_on    = buz_d;
    res.system_mode  = ui_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q   <= '0;
      act_q    <= ActionDefaultRst;
      alm_q    <= AlarmDefaultRst;
      ui_q     <= UiNormal;
      relay_q  <= 1'b0;
      alflag_q <= 1'b0;
      buz_q    <= 1'b0;
      st_q     <= '0;
      bt_q     <= '0;
    end else if (fire_i) begin
      temp_q   <= temp_d;
      act_q    <= act_d;
      alm_q    <= alm_d;
      ui_q     <= ui_d;
      relay_q  <= relay_d;
      alflag_q <= alflag_d;
      buz_q    <= buz_d;
      st_q     <= st_d;
      bt_q     <= bt_d;
    end
  end

  assign res_o = res;

endmodule
